[rtl/rpn_stack_calculator_defines.svh]
// Assertion macros used by the calculator checker
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// same-cycle implication
`define RPN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RPN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rpn_pkg.sv]
// Types and constants of the RPN stack calculator
`default_nettype none

package rpn_pkg;

  typedef enum logic [3:0] {
    K_PUSH  = 4'd0,
    K_PRINT = 4'd1,
    K_ADD   = 4'd2,
    K_SUB   = 4'd3,
    K_MUL   = 4'd4,
    K_DIV   = 4'd5,
    K_IDIV  = 4'd6,
    K_MOD   = 4'd7,
    K_POW   = 4'd8,
    K_SQRT  = 4'd9,
    K_FACT  = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    ST_VALUE = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FEW   = 3'd2,
    ST_FULL  = 3'd3,
    ST_DIV0  = 3'd4,
    ST_OVF   = 3'd5
  } status_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [63:0] operand;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [63:0] value;
  } out_t;

  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

  // n! for n = 0 .. 12
  localparam logic [31:0] FACT_TBL [13] = '{
    32'd1, 32'd1, 32'd2, 32'd6, 32'd24, 32'd120, 32'd720, 32'd5040,
    32'd40320, 32'd362880, 32'd3628800, 32'd39916800, 32'd479001600
  };

endpackage

`default_nettype wire

[rtl/rpn_stack_calculator.sv]
// RPN calculator over a stack of signed Q32.32 values, bit-serial multiply, divide and root
//
//   channel   dir  payload                  handshake
//   in        in   in_data_i  (kind, operand) in_valid_i / in_ready_o
//   out       out  out_data_o (status, value) out_valid_o / out_ready_i
//
// One request at a time. Multiply, divide, int divide/mod, square root and power run as
// shift/add-subtract or exponent-step loops, one bit (two for root, one exponent step for
// power) per cycle. An error status also passes through the emit state.
// Reset empties the stack at once; stack contents are not cleared.
// A result waiting on out_ready_i stalls only a request that produces the next result; later ones wait behind it.
`default_nettype none

module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam logic [DW-1:0] FULL_LVL = DW'(STACK_DEPTH);
  localparam logic [33:0]   POW_CAP  = 34'h2_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_SETUP, S_MUL, S_DIV, S_SQRT, S_POW, S_DONE, S_EMIT
  } state_e;

  state_e        state_q;
  logic [DW-1:0] depth_q;
  logic [3:0]    kind_q;
  logic [63:0]   a_q, b_q, res_q, rd_data_q;
  status_e       st_q;
  logic [127:0]  acc_q;
  logic [63:0]   mc_q, mp_q, d_q, rem_q, q_q;
  logic [95:0]   n_q;
  logic          big_q;
  logic [6:0]    cnt_q;
  logic [33:0]   pr_q;
  logic [31:0]   pe_q;
  logic          out_valid_q;
  out_t          out_q;

  logic [63:0]   stack_mem [STACK_DEPTH];

  logic          in_acc, is_bin_in, is_un_in, rd_go, push_ok;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [63:0]   wr_data;
  logic [DW-1:0] depth_m1, depth_m2;
  logic          bin_q;

  logic [63:0]   mag_a, mag_b, add_r, sub_r;
  logic [31:0]   ia_mag, ib_mag;
  logic          ia_neg, ib_neg, pow_neg, pow_done;
  logic [64:0]   mul_sum, div_t, div_diff;
  logic          div_ge;
  logic [63:0]   sq_t, sq_trial;
  logic          sq_ge;
  logic [65:0]   pow_prod;
  logic [33:0]   pow_next;

  function automatic logic [64:0] pack_q(input logic neg, input logic [63:0] mag,
                                         input logic big);
    logic [64:0] r;
    if (neg) begin
      if (big || (mag > Q_MIN)) r = {1'b1, Q_MIN};
      else r = {1'b0, ~mag + 64'd1};
    end else begin
      if (big || mag[63]) r = {1'b1, Q_MAX};
      else r = {1'b0, mag};
    end
    return r;
  endfunction

  function automatic status_e ovf_st(input logic ovf);
    return ovf ? ST_OVF : ST_VALUE;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    in_acc    = in_valid_i && (state_q == S_IDLE);
    is_bin_in = (in_data_i.kind >= K_ADD) && (in_data_i.kind <= K_POW);
    is_un_in  = (in_data_i.kind == K_SQRT) || (in_data_i.kind == K_FACT);
    bin_q     = (kind_q >= K_ADD) && (kind_q <= K_POW);
    depth_m1  = depth_q - DW'(1);
    depth_m2  = depth_q - DW'(2);
    push_ok   = (in_data_i.kind == K_PUSH) && (depth_q != FULL_LVL);
    rd_go     = ((in_data_i.kind == K_PRINT) && (depth_q != '0)) ||
                (is_bin_in && (depth_q >= DW'(2))) ||
                (is_un_in && (depth_q != '0));

    wr_en   = (in_acc && push_ok) || (state_q == S_DONE);
    wr_addr = depth_q[AW-1:0];
    wr_data = (state_q == S_DONE) ? res_q : in_data_i.operand;
    rd_en   = (in_acc && rd_go) || ((state_q == S_RD1) && bin_q);
    rd_addr = (state_q == S_RD1) ? depth_m2[AW-1:0] : depth_m1[AW-1:0];

    mag_a  = a_q[63] ? (64'd0 - a_q) : a_q;
    mag_b  = b_q[63] ? (64'd0 - b_q) : b_q;
    ia_mag = mag_a[63:32];
    ib_mag = mag_b[63:32];
    ia_neg = a_q[63] && (ia_mag != '0);
    ib_neg = b_q[63] && (ib_mag != '0);
    add_r  = a_q + b_q;
    sub_r  = a_q - b_q;

    mul_sum  = {1'b0, acc_q[127:64]} + (mp_q[0] ? {1'b0, mc_q} : 65'd0);
    div_t    = {rem_q, n_q[95]};
    div_diff = div_t - {1'b0, d_q};
    div_ge   = (div_t >= {1'b0, d_q});
    sq_t     = {rem_q[61:0], n_q[95:94]};
    sq_trial = {q_q[61:0], 2'b01};
    sq_ge    = (sq_t >= sq_trial);

    pow_prod = pr_q * ia_mag;
    pow_next = (pow_prod > {32'd0, POW_CAP}) ? POW_CAP : pow_prod[33:0];
    pow_done = (pe_q == '0) || (pr_q == POW_CAP);
    pow_neg  = ia_neg && ib_mag[0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) stack_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [64:0] pk;
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            kind_q <= in_data_i.kind;
            if (in_data_i.kind == K_PUSH) begin
              if (push_ok) depth_q <= depth_q + DW'(1);
              else begin
                st_q    <= ST_FULL;
                state_q <= S_EMIT;
              end
            end else if (in_data_i.kind == K_PRINT || is_bin_in || is_un_in) begin
              if (rd_go) state_q <= S_RD1;
              else begin
                st_q    <= (in_data_i.kind == K_PRINT) ? ST_EMPTY : ST_FEW;
                state_q <= S_EMIT;
              end
            end
          end
        end
        S_RD1: begin
          if (kind_q == K_PRINT) begin
            res_q   <= rd_data_q;
            st_q    <= ST_VALUE;
            depth_q <= depth_m1;
            state_q <= S_EMIT;
          end else if (bin_q) begin
            b_q     <= rd_data_q;
            depth_q <= depth_m2;
            state_q <= S_RD2;
          end else begin
            a_q     <= rd_data_q;
            depth_q <= depth_m1;
            state_q <= S_SETUP;
          end
        end
        S_RD2: begin
          a_q     <= rd_data_q;
          state_q <= S_SETUP;
        end
        S_SETUP: begin
          rem_q   <= '0;
          q_q     <= '0;
          big_q   <= 1'b0;
          unique case (kind_q)
            K_ADD: begin
              state_q <= S_DONE;
              if ((a_q[63] == b_q[63]) && (add_r[63] != a_q[63])) begin
                res_q <= a_q[63] ? Q_MIN : Q_MAX;
                st_q  <= ST_OVF;
              end else begin
                res_q <= add_r;
                st_q  <= ST_VALUE;
              end
            end
            K_SUB: begin
              state_q <= S_DONE;
              if ((a_q[63] != b_q[63]) && (sub_r[63] != a_q[63])) begin
                res_q <= a_q[63] ? Q_MIN : Q_MAX;
                st_q  <= ST_OVF;
              end else begin
                res_q <= sub_r;
                st_q  <= ST_VALUE;
              end
            end
            K_MUL: begin
              mc_q    <= mag_a;
              mp_q    <= mag_b;
              acc_q   <= '0;
              cnt_q   <= 7'd64;
              state_q <= S_MUL;
            end
            K_DIV: begin
              if (b_q == '0) begin
                st_q    <= ST_DIV0;
                res_q   <= (a_q == '0) ? 64'd0 : (a_q[63] ? Q_MIN : Q_MAX);
                state_q <= S_DONE;
              end else begin
                n_q     <= {mag_a, 32'd0};
                d_q     <= mag_b;
                cnt_q   <= 7'd96;
                state_q <= S_DIV;
              end
            end
            K_IDIV, K_MOD: begin
              if (ib_mag == '0) begin
                st_q    <= ST_DIV0;
                res_q   <= ((kind_q == K_IDIV) && (ia_mag != '0)) ?
                           (ia_neg ? Q_MIN : Q_MAX) : 64'd0;
                state_q <= S_DONE;
              end else begin
                n_q     <= {ia_mag, 64'd0};
                d_q     <= {32'd0, ib_mag};
                cnt_q   <= 7'd32;
                state_q <= S_DIV;
              end
            end
            K_POW: begin
              if (ib_neg && (ia_mag == '0)) begin
                st_q    <= ST_DIV0;
                res_q   <= Q_MAX;
                state_q <= S_DONE;
              end else begin
                state_q <= S_POW;
                if (ia_mag <= 32'd1) begin
                  pr_q <= (ia_mag[0] || (ib_mag == '0)) ? 34'd1 : 34'd0;
                  pe_q <= '0;
                end else begin
                  pr_q <= 34'd1;
                  pe_q <= ib_mag;
                end
              end
            end
            K_SQRT: begin
              if (ia_neg) begin
                st_q    <= ST_OVF;
                res_q   <= '0;
                state_q <= S_DONE;
              end else begin
                n_q     <= {ia_mag, 64'd0};
                cnt_q   <= 7'd48;
                state_q <= S_SQRT;
              end
            end
            K_FACT: begin
              state_q <= S_DONE;
              if (!ia_neg && (ia_mag > 32'd12)) begin
                st_q  <= ST_OVF;
                res_q <= Q_MAX;
              end else begin
                st_q  <= ST_VALUE;
                res_q <= {(ia_neg ? 32'd1 : FACT_TBL[ia_mag[3:0]]), 32'd0};
              end
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_MUL: begin
          if (cnt_q == '0) begin
            pk      = pack_q(a_q[63] ^ b_q[63], acc_q[95:32], |acc_q[127:96]);
            res_q   <= pk[63:0];
            st_q    <= ovf_st(pk[64]);
            state_q <= S_DONE;
          end else begin
            acc_q <= {mul_sum, acc_q[63:1]};
            mp_q  <= mp_q >> 1;
            cnt_q <= cnt_q - 7'd1;
          end
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_DONE;
            unique case (kind_q)
              K_DIV:  pk = pack_q(a_q[63] ^ b_q[63], q_q, big_q);
              K_IDIV: pk = pack_q(ia_neg ^ ib_neg, {q_q[31:0], 32'd0}, 1'b0);
              K_MOD:  pk = pack_q(ia_neg, {rem_q[31:0], 32'd0}, 1'b0);
              default: pk = {1'b0, pow_neg ? (64'd0 - q_q) : q_q};
            endcase
            res_q <= pk[63:0];
            st_q  <= ovf_st(pk[64]);
          end else begin
            rem_q <= div_ge ? div_diff[63:0] : div_t[63:0];
            q_q   <= {q_q[62:0], div_ge};
            big_q <= big_q | q_q[63];
            n_q   <= n_q << 1;
            cnt_q <= cnt_q - 7'd1;
          end
        end
        S_SQRT: begin
          if (cnt_q == '0) begin
            res_q   <= q_q;
            st_q    <= ST_VALUE;
            state_q <= S_DONE;
          end else begin
            rem_q <= sq_ge ? (sq_t - sq_trial) : sq_t;
            q_q   <= {q_q[62:0], sq_ge};
            n_q   <= n_q << 2;
            cnt_q <= cnt_q - 7'd1;
          end
        end
        S_POW: begin
          if (pow_done) begin
            if (!ib_neg) begin
              pk      = pack_q(pow_neg, {pr_q[31:0], 32'd0}, pr_q > 34'h0_8000_0000);
              res_q   <= pk[63:0];
              st_q    <= ovf_st(pk[64]);
              state_q <= S_DONE;
            end else if (pr_q > 34'h1_0000_0000) begin
              res_q   <= '0;
              st_q    <= ST_VALUE;
              state_q <= S_DONE;
            end else begin
              n_q     <= {33'h1_0000_0000, 63'd0};
              d_q     <= {30'd0, pr_q};
              rem_q   <= '0;
              q_q     <= '0;
              big_q   <= 1'b0;
              cnt_q   <= 7'd33;
              state_q <= S_DIV;
            end
          end else begin
            pr_q <= pow_next;
            pe_q <= pe_q - 32'd1;
          end
        end
        S_DONE: begin
          depth_q <= depth_q + DW'(1);
          state_q <= (st_q != ST_VALUE) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.status <= st_q;
            out_q.value  <= (st_q == ST_VALUE) ? res_q : 64'd0;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/rpn_chk.sv]
// Port-level checker for the RPN stack calculator, bound to the top level
`default_nettype none
`include "rpn_stack_calculator_defines.svh"

module rpn_chk
  import rpn_pkg::*;
(
  input wire  clk_i,
  input wire  rst_ni,
  input wire  in_valid_i,
  input wire  in_ready_o,
  input in_t  in_data_i,
  input wire  out_valid_o,
  input wire  out_ready_i,
  input out_t out_data_o
);

  `RPN_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `RPN_ASSERT_IMP(a_status_rng, clk_i, rst_ni, out_valid_o, out_data_o.status <= ST_OVF, "status code out of range")
  `RPN_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.status != ST_VALUE, out_data_o.value == 64'sd0, "error result carries a value")
  `RPN_ASSERT_NXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o && in_data_i.kind >= K_PRINT && in_data_i.kind <= K_FACT, !in_ready_o, "operation request did not occupy the block")

endmodule

bind rpn_stack_calculator rpn_chk u_rpn_chk (.*);

`default_nettype wire

[bench/rpn_stack_calculator_tb.sv]
// Self-checking bench for the RPN stack calculator: directed and random requests against a predictor
`default_nettype none

module rpn_stack_calculator_tb;
  import rpn_pkg::*;

  localparam int DEPTH = 64;
  localparam int LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] calc_stack [DEPTH];
  int calc_depth = 0;
  out_t expected_q [$];
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_status [8];
  int cycles = 0;
  bit hold_off = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] pack_sat(input bit neg, input logic [63:0] m, input bit big,
                                           inout bit ovf);
    if (neg) begin
      if (big || m > Q_MIN) begin
        ovf = 1'b1;
        return Q_MIN;
      end
      return -m;
    end
    if (big || m > Q_MAX) begin
      ovf = 1'b1;
      return Q_MAX;
    end
    return m;
  endfunction

  function automatic longint int_part(input logic [63:0] v);
    longint m;
    m = longint'(mag(v) >> 32);
    return v[63] ? -m : m;
  endfunction

  function automatic logic [63:0] from_integer(input longint q, inout bit ovf);
    logic [63:0] m;
    m = q < 0 ? -q : q;
    return pack_sat(q < 0, m << 32, m > 64'h8000_0000, ovf);
  endfunction

  function automatic logic [63:0] capped_mul(input logic [63:0] x, input logic [63:0] y,
                                             input logic [63:0] cap);
    logic [127:0] p;
    p = x * y;
    if (x == 0 || y == 0) return 0;
    return p > {64'd0, cap} ? cap : p[63:0];
  endfunction

  function automatic logic [63:0] capped_pow(input logic [63:0] base, input logic [63:0] e,
                                             input logic [63:0] cap);
    logic [63:0] r, x;
    r = 1;
    x = base;
    while (e != 0) begin
      if (e[0]) r = capped_mul(r, x, cap);
      e = e >> 1;
      if (e != 0) x = capped_mul(x, x, cap);
    end
    return r;
  endfunction

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b, inout bit ovf);
    logic [127:0] p;
    p = mag(a) * mag(b);
    return pack_sat(a[63] != b[63], p[95:32], p[127:96] != 0, ovf);
  endfunction

  function automatic logic [63:0] fx_div(input logic [63:0] a, input logic [63:0] b, inout bit ovf);
    logic [127:0] q;
    q = {mag(a), 64'd0} >> 32;
    q = q / {64'd0, mag(b)};
    return pack_sat(a[63] != b[63], q[63:0], q[127:64] != 0, ovf);
  endfunction

  function automatic logic [63:0] fx_pow(input longint a, input longint b, inout status_e st);
    logic [63:0] ma, mb, m, q;
    bit neg, ovf;
    ovf = 1'b0;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = a < 0 && mb[0];
    if (b >= 0) begin
      m = capped_pow(ma, mb, 64'h1_0000_0000);
      q = pack_sat(neg, m << 32, m > 64'h8000_0000, ovf);
      if (ovf) st = ST_OVF;
      return q;
    end
    if (ma == 0) begin
      st = ST_DIV0;
      return Q_MAX;
    end
    m = capped_pow(ma, mb, 64'h2_0000_0000);
    q = m > 64'h1_0000_0000 ? 64'd0 : 64'h1_0000_0000 / m;
    return neg ? -q : q;
  endfunction

  function automatic logic [63:0] fx_sqrt(input longint a);
    logic [63:0] r, t;
    logic [127:0] sq;
    r = 0;
    for (int b = 47; b >= 0; b--) begin
      t = r | (64'd1 << b);
      sq = t * t;
      if (sq[127:64] < a || (sq[127:64] == a && sq[63:0] == 0)) r = t;
    end
    return r;
  endfunction

  // works out the stack effect and any result the block should return
  function automatic void evaluate(input in_t req);
    logic [63:0] a, b, r;
    status_e st;
    bit ovf;
    longint x, y, f;
    out_t res;
    st = ST_VALUE;
    ovf = 1'b0;
    a = 0;
    b = 0;
    r = 0;
    if (req.kind > K_FACT) return;
    if (req.kind == K_PUSH) begin
      if (calc_depth >= DEPTH) begin
        res = '{ST_FULL, 64'd0};
        expected_q.push_back(res);
      end else begin
        calc_stack[calc_depth++] = req.operand;
      end
      return;
    end
    if (req.kind == K_PRINT) begin
      if (calc_depth == 0) res = '{ST_EMPTY, 64'd0};
      else res = '{ST_VALUE, calc_stack[--calc_depth]};
      expected_q.push_back(res);
      return;
    end
    if (req.kind >= K_SQRT) begin
      if (calc_depth < 1) begin
        res = '{ST_FEW, 64'd0};
        expected_q.push_back(res);
        return;
      end
      a = calc_stack[--calc_depth];
    end else begin
      if (calc_depth < 2) begin
        res = '{ST_FEW, 64'd0};
        expected_q.push_back(res);
        return;
      end
      b = calc_stack[--calc_depth];
      a = calc_stack[--calc_depth];
    end
    x = int_part(a);
    y = int_part(b);
    case (kind_e'(req.kind))
      K_ADD: begin
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
          ovf = 1'b1;
          r = a[63] ? Q_MIN : Q_MAX;
        end
      end
      K_SUB: begin
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
          ovf = 1'b1;
          r = a[63] ? Q_MIN : Q_MAX;
        end
      end
      K_MUL: r = fx_mul(a, b, ovf);
      K_DIV: begin
        if (b == 0) begin
          st = ST_DIV0;
          r = a == 0 ? 64'd0 : (a[63] ? Q_MIN : Q_MAX);
        end else begin
          r = fx_div(a, b, ovf);
        end
      end
      K_IDIV: begin
        if (y == 0) begin
          st = ST_DIV0;
          r = x == 0 ? 64'd0 : (x < 0 ? Q_MIN : Q_MAX);
        end else begin
          r = from_integer(x / y, ovf);
        end
      end
      K_MOD: begin
        if (y == 0) begin
          st = ST_DIV0;
          r = 0;
        end else begin
          r = from_integer(x % y, ovf);
        end
      end
      K_POW: r = fx_pow(x, y, st);
      K_SQRT: begin
        if (x < 0) begin
          st = ST_OVF;
          r = 0;
        end else begin
          r = fx_sqrt(x);
        end
      end
      default: begin
        if (x > 12) begin
          ovf = 1'b1;
          r = Q_MAX;
        end else begin
          f = 1;
          for (longint i = 2; i <= x; i++) f *= i;
          r = from_integer(f, ovf);
        end
      end
    endcase
    calc_stack[calc_depth++] = r;
    if (ovf && st == ST_VALUE) st = ST_OVF;
    if (st != ST_VALUE) begin
      res = '{st, 64'd0};
      expected_q.push_back(res);
    end
  endfunction

  // valid is dropped here only when an idle gap follows; stop_sending ends a burst
  task automatic send(input logic [3:0] kind, input logic [63:0] operand);
    in_t req;
    int gap;
    req.kind = kind;
    req.operand = operand;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    evaluate(req);
    n_requests++;
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver with random stalls, plus a long hold-off on request
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        out_ready_i <= 1'b1;
      end else if (out_valid_o) begin
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          repeat (gap - 1) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      n_status[out_data_o.status]++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result status %0d", out_data_o.status));
      end else begin
        exp_res = expected_q.pop_front();
        if (out_data_o.status != exp_res.status)
          report($sformatf("status %0d, expected %0d", out_data_o.status, exp_res.status));
        if (out_data_o.value != exp_res.value)
          report($sformatf("value %h, expected %h", out_data_o.value, exp_res.value));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_small();
    logic [63:0] v;
    v = {32'(int'($urandom_range(0, 40)) - 20), $urandom()};
    if ($urandom_range(0, 3) == 0) v[31:0] = 0;
    return v;
  endfunction

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      2: return 64'd0;
      default: return rand_small();
    endcase
  endfunction

  task automatic drain();
    while (calc_depth > 0) send(K_PRINT, rand64());
  endtask

  task automatic test_errors();
    send(K_PRINT, '0);
    send(K_ADD, '0);
    send(K_SQRT, '0);
    send(4'd11, '1);
    send(4'd15, '0);
    for (int i = 0; i < DEPTH; i++) send(K_PUSH, i[0] ? Q_MAX : Q_MIN);
    send(K_PUSH, rand64());
    send(K_ADD, '0);
    drain();
  endtask

  task automatic test_ops();
    logic [63:0] pairs [6][2] = '{
      '{Q_MAX, Q_MAX}, '{Q_MIN, 64'd0}, '{64'h5_8000_0000, 64'hFFFF_FFFD_0000_0000},
      '{64'hFFFF_FFFE_0000_0000, 64'hFFFF_FFFD_0000_0000}, '{64'd0, 64'hFFFF_FFFF_0000_0000},
      '{64'h0000_0003_0000_0000, 64'h0000_0011_0000_0000}};
    for (int k = K_ADD; k <= K_POW; k++)
      foreach (pairs[p]) begin
        send(K_PUSH, pairs[p][0]);
        send(K_PUSH, pairs[p][1]);
        send(k[3:0], '0);
        send(K_PRINT, '0);
      end
    foreach (pairs[p]) begin
      send(K_PUSH, pairs[p][0]);
      send(K_SQRT, '0);
      send(K_PUSH, pairs[p][1]);
      send(K_FACT, '0);
      send(K_PRINT, '0);
      send(K_PRINT, '0);
    end
  endtask

  task automatic test_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) send(4'($urandom_range(11, 15)), rand64());
      else if (r < 40 || calc_depth < 2) send(K_PUSH, rand_operand());
      else if (r < 55) send(K_PRINT, '0);
      else send(4'($urandom_range(K_ADD, K_FACT)), '0);
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 6; i++) send(K_PRINT, '0);
        stop_sending();
      end
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_errors();
    test_ops();
    stop_sending();
    test_backpressure();
    test_random(1000);
    stop_sending();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d requests, %0d results; status counts %0d %0d %0d %0d %0d %0d",
             n_requests, n_results, n_status[0], n_status[1], n_status[2],
             n_status[3], n_status[4], n_status[5]);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
